FILE: rtl/pbenc_pkg.sv
// Shared constants, command and status types of the PackBits encoder.
package pbenc_pkg;

    localparam int BYTE_W     = 8;
    localparam int OUT_W      = 64;
    localparam int CNT_W      = 4;
    localparam int MAX_PACKET = 128;
    localparam int OUT_LANES  = 8;

    localparam int LEN_W     = $clog2(MAX_PACKET + 1);
    localparam int ADDR_W    = $clog2(MAX_PACKET);
    localparam int LANE_BITS = OUT_LANES * BYTE_W;

    // Updates of the run tracking registers.
    typedef enum logic [2:0] {
        ST_KEEP,
        ST_NEW_RUN,
        ST_RUN_INC,
        ST_RUN_PAIR,
        ST_RUN_ONE,
        ST_CLEAR
    } state_op_t;

    // Source of the byte offered to the word packer.
    typedef enum logic [2:0] {
        EM_NONE,
        EM_HDR,
        EM_BODY,
        EM_RCNT,
        EM_RVAL
    } emit_t;

    typedef struct packed {
        state_op_t state_op;
        logic      lit_wr;
        logic      lit_clr;
        logic      rep_latch;
        emit_t     emit;
        logic      flush;
        logic      flush_last;
    } dp_cmd_t;

    typedef struct packed {
        logic run_zero;
        logic same;
        logic in_repeat;
        logic run_full;
        logic len_zero;
        logic len_near_full;
        logic byte_acc;
        logic body_end;
        logic word_done;
    } dp_stat_t;

endpackage

FILE: rtl/pbenc_in_if.sv
// Input channel interface of the PackBits encoder: one raw byte per beat.
interface pbenc_in_if;
    logic                          valid;
    logic                          ready;
    logic [pbenc_pkg::BYTE_W-1:0]  in_byte;
    logic                          in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: rtl/pbenc_out_if.sv
// Output channel interface of the PackBits encoder: one packed word per beat.
interface pbenc_out_if;
    logic                         valid;
    logic                         ready;
    logic [pbenc_pkg::OUT_W-1:0]  out_bytes;
    logic [pbenc_pkg::CNT_W-1:0]  out_count;
    logic                         out_last;

    modport source (output valid, output out_bytes, output out_count, output out_last,
                    input ready);
    modport sink (input valid, input out_bytes, input out_count, input out_last,
                  output ready);
endinterface

FILE: rtl/pbenc_dp.sv
// Datapath of the PackBits encoder: run tracking, literal store and word packer.
module pbenc_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pbenc_pkg::BYTE_W-1:0]  in_byte,
    input  pbenc_pkg::dp_cmd_t            cmd,
    output pbenc_pkg::dp_stat_t           stat,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [pbenc_pkg::OUT_W-1:0]   out_bytes,
    output logic [pbenc_pkg::CNT_W-1:0]   out_count,
    output logic                          out_last
);

    logic [pbenc_pkg::BYTE_W-1:0]     held_reg;
    logic [pbenc_pkg::LEN_W-1:0]      run_reg;
    logic                             rep_reg;
    logic [pbenc_pkg::LEN_W-1:0]      len_reg;
    logic [pbenc_pkg::ADDR_W-1:0]     idx_reg;
    logic [pbenc_pkg::LEN_W-1:0]      rcnt_reg;
    logic [pbenc_pkg::BYTE_W-1:0]     rval_reg;
    logic [pbenc_pkg::BYTE_W-1:0]     rdata_reg;
    logic [pbenc_pkg::BYTE_W-1:0]     store_mem [pbenc_pkg::MAX_PACKET];

    logic [pbenc_pkg::LANE_BITS-1:0]  asm_word_reg;
    logic [pbenc_pkg::LANE_BITS-1:0]  asm_word_next;
    logic [pbenc_pkg::CNT_W-1:0]      asm_cnt_reg;
    logic [pbenc_pkg::CNT_W-1:0]      asm_cnt_next;

    logic                             out_valid_reg;
    logic [pbenc_pkg::OUT_W-1:0]      out_bytes_reg;
    logic [pbenc_pkg::CNT_W-1:0]      out_count_reg;
    logic                             out_last_reg;

    logic [pbenc_pkg::BYTE_W-1:0]     emit_byte;
    logic [pbenc_pkg::BYTE_W:0]       rcnt_diff;
    logic [pbenc_pkg::ADDR_W-1:0]     rd_addr;
    logic                             emit_req;
    logic                             asm_full;
    logic                             out_free;
    logic                             move;
    logic                             byte_acc;
    logic                             adv;

    // Repeat count byte is (257 - run) modulo 256.
    assign rcnt_diff = (pbenc_pkg::BYTE_W + 1)'(257) - (pbenc_pkg::BYTE_W + 1)'(rcnt_reg);

    always_comb
    begin
        case (cmd.emit)
            pbenc_pkg::EM_HDR:  emit_byte = pbenc_pkg::BYTE_W'(len_reg - pbenc_pkg::LEN_W'(1));
            pbenc_pkg::EM_BODY: emit_byte = rdata_reg;
            pbenc_pkg::EM_RCNT: emit_byte = rcnt_diff[pbenc_pkg::BYTE_W-1:0];
            pbenc_pkg::EM_RVAL: emit_byte = rval_reg;
            default:            emit_byte = '0;
        endcase
    end

    assign emit_req = (cmd.emit != pbenc_pkg::EM_NONE);
    assign asm_full = (asm_cnt_reg == pbenc_pkg::CNT_W'(pbenc_pkg::OUT_LANES));
    assign out_free = !out_valid_reg || out_ready;
    assign move     = out_free && (asm_full || (cmd.flush && (asm_cnt_reg != '0)));
    assign byte_acc = emit_req && (!asm_full || move);
    assign adv      = (cmd.emit == pbenc_pkg::EM_BODY) && byte_acc;

    // While a body byte stalls, the same entry is read again so the data stays put.
    assign rd_addr = (cmd.emit == pbenc_pkg::EM_HDR) ? '0
                   : idx_reg + pbenc_pkg::ADDR_W'(adv);

    always_comb
    begin
        asm_word_next = asm_word_reg;
        asm_cnt_next  = asm_cnt_reg;
        if (move)
        begin
            asm_word_next = '0;
            asm_cnt_next  = '0;
        end
        if (byte_acc)
        begin
            for (int i = 0; i < pbenc_pkg::OUT_LANES; i++)
            begin
                if (pbenc_pkg::CNT_W'(i) == asm_cnt_next)
                begin
                    asm_word_next[i*pbenc_pkg::BYTE_W +: pbenc_pkg::BYTE_W] = emit_byte;
                end
            end
            asm_cnt_next = asm_cnt_next + pbenc_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lit_wr)
        begin
            store_mem[len_reg[pbenc_pkg::ADDR_W-1:0]] <= held_reg;
        end
        rdata_reg <= store_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            run_reg       <= '0;
            rep_reg       <= 1'b0;
            len_reg       <= '0;
            idx_reg       <= '0;
            asm_word_reg  <= '0;
            asm_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (cmd.state_op)
                pbenc_pkg::ST_KEEP: ;
                pbenc_pkg::ST_NEW_RUN:
                begin
                    held_reg <= in_byte;
                    run_reg  <= pbenc_pkg::LEN_W'(1);
                    rep_reg  <= 1'b0;
                end
                pbenc_pkg::ST_RUN_INC:  run_reg <= run_reg + pbenc_pkg::LEN_W'(1);
                pbenc_pkg::ST_RUN_PAIR:
                begin
                    run_reg <= pbenc_pkg::LEN_W'(2);
                    rep_reg <= 1'b1;
                end
                pbenc_pkg::ST_RUN_ONE:
                begin
                    run_reg <= pbenc_pkg::LEN_W'(1);
                    rep_reg <= 1'b0;
                end
                pbenc_pkg::ST_CLEAR:
                begin
                    held_reg <= '0;
                    run_reg  <= '0;
                    rep_reg  <= 1'b0;
                end
                default: ;
            endcase

            if (cmd.lit_clr || (cmd.state_op == pbenc_pkg::ST_CLEAR))
            begin
                len_reg <= '0;
            end
            else if (cmd.lit_wr)
            begin
                len_reg <= len_reg + pbenc_pkg::LEN_W'(1);
            end

            if ((cmd.emit == pbenc_pkg::EM_HDR) && byte_acc)
            begin
                idx_reg <= '0;
            end
            else if (adv)
            begin
                idx_reg <= idx_reg + pbenc_pkg::ADDR_W'(1);
            end

            asm_word_reg <= asm_word_next;
            asm_cnt_reg  <= asm_cnt_next;

            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rep_latch)
        begin
            rcnt_reg <= run_reg;
            rval_reg <= held_reg;
        end
        if (move)
        begin
            out_bytes_reg <= pbenc_pkg::OUT_W'(asm_word_reg);
            out_count_reg <= asm_cnt_reg;
            out_last_reg  <= cmd.flush_last;
        end
    end

    assign stat.run_zero      = (run_reg == '0);
    assign stat.same          = (in_byte == held_reg);
    assign stat.in_repeat     = rep_reg;
    assign stat.run_full      = (run_reg == pbenc_pkg::LEN_W'(pbenc_pkg::MAX_PACKET));
    assign stat.len_zero      = (len_reg == '0);
    assign stat.len_near_full = (len_reg == pbenc_pkg::LEN_W'(pbenc_pkg::MAX_PACKET - 1));
    assign stat.byte_acc      = byte_acc;
    assign stat.body_end      = (pbenc_pkg::LEN_W'(idx_reg) == len_reg - pbenc_pkg::LEN_W'(1));
    assign stat.word_done     = cmd.flush && (move || (asm_cnt_reg == '0));

    assign out_valid = out_valid_reg;
    assign out_bytes = out_bytes_reg;
    assign out_count = out_count_reg;
    assign out_last  = out_last_reg;

endmodule

FILE: rtl/pbenc_ctrl.sv
// Controller of the PackBits encoder: sequences packets and word ends per input beat.
module pbenc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    input  pbenc_pkg::dp_stat_t  stat,
    output pbenc_pkg::dp_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FLUSH_RUN,
        S_REP_COUNT,
        S_REP_VALUE,
        S_LIT_HEAD,
        S_LIT_BODY,
        S_WORD_END
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    state_t                 after_pkt;
    logic                   last_reg;
    logic                   last_next;
    logic                   post_reg;
    logic                   post_next;

    pbenc_pkg::state_op_t   op;
    logic                   lit_wr;
    logic                   lit_clr;
    logic                   rep_latch;
    pbenc_pkg::emit_t       emit;
    logic                   flush;
    logic                   flush_last;

    // Byte sources and word end depend on the state alone.
    always_comb
    begin
        emit       = pbenc_pkg::EM_NONE;
        flush      = 1'b0;
        flush_last = 1'b0;
        case (state_reg)
            S_REP_COUNT: emit = pbenc_pkg::EM_RCNT;
            S_REP_VALUE: emit = pbenc_pkg::EM_RVAL;
            S_LIT_HEAD:  emit = pbenc_pkg::EM_HDR;
            S_LIT_BODY:  emit = pbenc_pkg::EM_BODY;
            S_WORD_END:
            begin
                flush      = 1'b1;
                flush_last = last_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        post_next  = post_reg;
        op         = pbenc_pkg::ST_KEEP;
        lit_wr     = 1'b0;
        lit_clr    = 1'b0;
        rep_latch  = 1'b0;
        in_ready   = 1'b0;
        // Once the pre-update packet is out, a final beat still has its held run to flush.
        after_pkt  = (last_reg && !post_reg) ? S_FLUSH_RUN : S_WORD_END;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    last_next  = in_last;
                    post_next  = 1'b0;
                    state_next = in_last ? S_FLUSH_RUN : S_IDLE;
                    if (stat.run_zero)
                    begin
                        op = pbenc_pkg::ST_NEW_RUN;
                    end
                    else if (stat.same)
                    begin
                        if (!stat.in_repeat)
                        begin
                            op = pbenc_pkg::ST_RUN_PAIR;
                            if (!stat.len_zero)
                            begin
                                state_next = S_LIT_HEAD;
                            end
                        end
                        else if (!stat.run_full)
                        begin
                            op = pbenc_pkg::ST_RUN_INC;
                        end
                        else
                        begin
                            op         = pbenc_pkg::ST_RUN_ONE;
                            rep_latch  = 1'b1;
                            state_next = S_REP_COUNT;
                        end
                    end
                    else
                    begin
                        op = pbenc_pkg::ST_NEW_RUN;
                        if (stat.in_repeat)
                        begin
                            rep_latch  = 1'b1;
                            state_next = S_REP_COUNT;
                        end
                        else
                        begin
                            lit_wr = 1'b1;
                            if (stat.len_near_full)
                            begin
                                state_next = S_LIT_HEAD;
                            end
                        end
                    end
                end
            end

            S_FLUSH_RUN:
            begin
                post_next = 1'b1;
                if (stat.in_repeat)
                begin
                    rep_latch  = 1'b1;
                    state_next = S_REP_COUNT;
                end
                else
                begin
                    lit_wr     = 1'b1;
                    state_next = S_LIT_HEAD;
                end
            end

            S_REP_COUNT:
            begin
                if (stat.byte_acc)
                begin
                    state_next = S_REP_VALUE;
                end
            end

            S_REP_VALUE:
            begin
                if (stat.byte_acc)
                begin
                    state_next = after_pkt;
                end
            end

            S_LIT_HEAD:
            begin
                if (stat.byte_acc)
                begin
                    state_next = S_LIT_BODY;
                end
            end

            S_LIT_BODY:
            begin
                if (stat.byte_acc && stat.body_end)
                begin
                    lit_clr    = 1'b1;
                    state_next = after_pkt;
                end
            end

            S_WORD_END:
            begin
                if (stat.word_done)
                begin
                    if (last_reg)
                    begin
                        op = pbenc_pkg::ST_CLEAR;
                    end
                    last_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
            post_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            post_reg  <= post_next;
        end
    end

    assign cmd = '{state_op:   op,
                   lit_wr:     lit_wr,
                   lit_clr:    lit_clr,
                   rep_latch:  rep_latch,
                   emit:       emit,
                   flush:      flush,
                   flush_last: flush_last};

endmodule

FILE: rtl/packbits_encoder_core.sv
// Top level of the streaming PackBits run-length encoder.
//
// Usage: raw bytes enter on the raw channel, one byte per beat, with in_last
// set on the final byte of a stream. Encoded PackBits packets leave on the
// coded channel as words of up to eight bytes, first byte in the lowest lane,
// out_count telling how many lanes hold data and out_last marking the final
// word of a stream. The words caused by one input beat are packed on their own;
// they never share a word with bytes of another beat.
// A beat that only extends a run or adds a byte to the pending literal is
// accepted while the encoder stays idle. A beat that sends a packet then emits
// its encoded bytes (count and value for a repeat packet, header and body for
// a literal) and closes the word; a final beat also flushes its held run as a
// packet before the word is closed. The word packer takes one byte per cycle
// unless its word and the output register are both full.
// Each word is registered in the output register and becomes valid once the
// packer has filled eight lanes or closed the word and that register is free.
// Reset clears the run tracking and the word packer at once; the literal store
// holds garbage but is only read where it was written. When the receiver
// stalls, one finished word waits in the output register while the packer
// fills the next; beyond that the encoder holds its input ready low.
module packbits_encoder_core (
    input  logic          clk,
    input  logic          rst_n,
    pbenc_in_if.sink      raw,
    pbenc_out_if.source   coded
);

    pbenc_pkg::dp_cmd_t            cmd;
    pbenc_pkg::dp_stat_t           stat;
    logic                          in_ready;
    logic                          out_valid;
    logic [pbenc_pkg::OUT_W-1:0]   out_bytes;
    logic [pbenc_pkg::CNT_W-1:0]   out_count;
    logic                          out_last;

    // The controller decides from status flags what each beat triggers.
    pbenc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (raw.valid),
        .in_last  (raw.in_last),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the run state, the literal bytes and the output word.
    pbenc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (raw.in_byte),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (coded.ready),
        .out_valid (out_valid),
        .out_bytes (out_bytes),
        .out_count (out_count),
        .out_last  (out_last)
    );

    assign raw.ready       = in_ready;
    assign coded.valid     = out_valid;
    assign coded.out_bytes = out_bytes;
    assign coded.out_count = out_count;
    assign coded.out_last  = out_last;

endmodule

FILE: rtl/pbenc_checker.sv
// Port-level checks of the PackBits encoder and their binding to the top level.
module pbenc_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          in_last,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [pbenc_pkg::OUT_W-1:0]   out_bytes,
    input  logic [pbenc_pkg::CNT_W-1:0]   out_count,
    input  logic                          out_last
);

    // A stalled word must not change under the receiver.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_bytes)
            && $stable(out_count) && $stable(out_last))
        else $error("output word changed while stalled");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_count != '0)
            && (out_count <= pbenc_pkg::CNT_W'(pbenc_pkg::OUT_LANES)))
        else $error("output lane count out of range");

    // Lanes above the count carry zero.
    a_unused_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_count < pbenc_pkg::CNT_W'(pbenc_pkg::OUT_LANES))
            |-> ((out_bytes >> {out_count, 3'b000}) == '0))
        else $error("unused output lanes not zero");

    // The final byte of a stream always yields output, so the encoder is busy next.
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("input accepted right after a final byte");

endmodule

bind packbits_encoder_core pbenc_checker u_pbenc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (raw.valid),
    .in_ready  (raw.ready),
    .in_last   (raw.in_last),
    .out_valid (coded.valid),
    .out_ready (coded.ready),
    .out_bytes (coded.out_bytes),
    .out_count (coded.out_count),
    .out_last  (coded.out_last)
);

FILE: verif/pbenc_word_checker.sv
// Checker for the PackBits encoder: predicts coded words from raw beats and compares them.
module pbenc_word_checker
    import pbenc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    pbenc_in_if  raw,
    pbenc_out_if coded,
    output int   mismatches,
    output int   words_due
);

    typedef struct packed {
        logic [OUT_W-1:0] lanes;
        logic [CNT_W-1:0] count;
        logic             last;
    } coded_word_t;

    logic [BYTE_W-1:0] lit_mem [MAX_PACKET];
    int                lit_len;
    logic [BYTE_W-1:0] run_byte;
    int                run_len;
    logic              repeating;
    logic [BYTE_W-1:0] packet_bytes [$];
    coded_word_t       expected_words [$];
    int                bad_words;

    function automatic void emit_literal();
        if (lit_len == 0)
            return;
        packet_bytes.push_back(BYTE_W'(lit_len - 1));
        for (int k = 0; k < lit_len; k++)
            packet_bytes.push_back(lit_mem[k]);
        lit_len = 0;
    endfunction

    function automatic void emit_repeat();
        packet_bytes.push_back(BYTE_W'(257 - run_len));
        packet_bytes.push_back(run_byte);
    endfunction

    function automatic void add_literal(input logic [BYTE_W-1:0] v);
        lit_mem[lit_len] = v;
        lit_len++;
        if (lit_len >= MAX_PACKET)
            emit_literal();
    endfunction

    // Works out the packets that one raw beat releases and packs them into words.
    function automatic void encode_beat(input logic [BYTE_W-1:0] b, input logic fin);
        coded_word_t word;
        int          n;
        packet_bytes.delete();
        if (run_len == 0)
        begin
            run_byte  = b;
            run_len   = 1;
            repeating = 1'b0;
        end
        else if (b == run_byte)
        begin
            if (!repeating)
            begin
                emit_literal();
                run_len   = 2;
                repeating = 1'b1;
            end
            else if (run_len < MAX_PACKET)
                run_len++;
            else
            begin
                emit_repeat();
                run_len   = 1;
                repeating = 1'b0;
            end
        end
        else
        begin
            if (repeating)
                emit_repeat();
            else
                add_literal(run_byte);
            run_byte  = b;
            run_len   = 1;
            repeating = 1'b0;
        end
        if (fin)
        begin
            if (repeating)
                emit_repeat();
            else if (run_len != 0)
                add_literal(run_byte);
            emit_literal();
            run_byte  = '0;
            run_len   = 0;
            repeating = 1'b0;
        end
        n = packet_bytes.size();
        for (int w = 0; w * OUT_LANES < n; w++)
        begin
            word = '0;
            for (int j = 0; j < OUT_LANES && w * OUT_LANES + j < n; j++)
            begin
                word.lanes[BYTE_W*j +: BYTE_W] = packet_bytes[w * OUT_LANES + j];
                word.count = CNT_W'(j + 1);
            end
            word.last = fin && ((w + 1) * OUT_LANES >= n);
            expected_words.push_back(word);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        coded_word_t want;
        if (!rst_n)
        begin
            lit_len   = 0;
            run_byte  = '0;
            run_len   = 0;
            repeating = 1'b0;
            expected_words.delete();
            bad_words = 0;
        end
        else
        begin
            if (raw.valid && raw.ready)
                encode_beat(raw.in_byte, raw.in_last);
            if (coded.valid && coded.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    if (bad_words < 10)
                        $display("unexpected coded word: bytes=%h count=%0d last=%b",
                                 coded.out_bytes, coded.out_count, coded.out_last);
                    bad_words++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (coded.out_bytes !== want.lanes || coded.out_count !== want.count ||
                        coded.out_last !== want.last)
                    begin
                        if (bad_words < 10)
                            $display({"coded word mismatch: expected bytes=%h count=%0d ",
                                      "last=%b, got bytes=%h count=%0d last=%b"},
                                     want.lanes, want.count, want.last,
                                     coded.out_bytes, coded.out_count, coded.out_last);
                        bad_words++;
                    end
                end
            end
        end
        mismatches <= bad_words;
        words_due  <= expected_words.size();
    end

endmodule

FILE: verif/packbits_encoder_core_test.sv
// Top of the PackBits encoder test: clock, reset, raw byte streams, receiver and verdict.
module packbits_encoder_core_test;

    import pbenc_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 12;
    // Cycles the receiver refuses words during the forced back-pressure stretch.
    localparam int HOLD_CYCLES  = 400;
    // Grace period after the last expected word: longer than the slowest beat.
    localparam int DRAIN_CYCLES = 200;
    // Watchdog: far beyond the slowest correct run of this stimulus.
    localparam int MAX_CYCLES   = 600000;

    // Content shapes of a generated stream.
    typedef enum {
        SEQ_MIXED,
        SEQ_NOISE,
        SEQ_RUN,
        SEQ_LITERAL
    } seq_kind_t;

    logic clk = 1'b0;
    logic rst_n;

    pbenc_in_if  raw ();
    pbenc_out_if coded ();

    int mismatches;
    int words_due;

    // Idle percentages of the two sides; the receiver's is read by its own process.
    int send_idle_pct = 35;
    int recv_idle_pct = 46;

    logic hold_go = 1'b0;
    logic stall_rx = 1'b0;

    logic [BYTE_W-1:0] stream_bytes [$];
    int items_sent = 0;

    packbits_encoder_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .raw   (raw),
        .coded (coded)
    );

    pbenc_word_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .raw        (raw),
        .coded      (coded),
        .mismatches (mismatches),
        .words_due  (words_due)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // Receiver: drops ready at random at the current idle rate, and holds it low for
    // the whole back-pressure stretch.
    initial
    begin : receiver
        coded.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            coded.ready <= rst_n && !stall_rx && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver stall, counted here so that the sender keeps offering beats
    // meanwhile; the encoder has to fill up and lower its input ready.
    initial
    begin : hold_off
        wait (hold_go);
        @(posedge clk);
        stall_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_rx <= 1'b0;
    end

    initial
    begin : watchdog
        #(2 * CLK_HALF * MAX_CYCLES);
        $display("FAIL packbits_encoder_core");
        $finish;
    end

    // Offers one raw beat and returns at the edge that accepts it. A random gap
    // of idle cycles, carrying junk data, may come first.
    task automatic send_beat(input logic [BYTE_W-1:0] b, input logic fin);
        int gap;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 4);
            raw.valid   <= 1'b0;
            raw.in_byte <= BYTE_W'($urandom);
            raw.in_last <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        raw.valid   <= 1'b1;
        raw.in_byte <= b;
        raw.in_last <= fin;
        @(posedge clk);
        while (raw.ready !== 1'b1)
            @(posedge clk);
        items_sent++;
    endtask

    // Sends the prepared stream, with in_last on its final byte.
    task automatic send_stream();
        for (int i = 0; i < stream_bytes.size(); i++)
            send_beat(stream_bytes[i], i == stream_bytes.size() - 1);
    endtask

    // Fills the stream buffer. Mixed streams are runs of random lengths, noise
    // draws often from a tiny alphabet so pairs appear by chance, run streams repeat
    // one value, and literal streams never repeat a byte twice in a row.
    task automatic build_stream(input seq_kind_t kind, input int len);
        logic [BYTE_W-1:0] v;
        int                run;
        stream_bytes.delete();
        v = BYTE_W'($urandom);
        while (stream_bytes.size() < len)
        begin
            case (kind)
                SEQ_MIXED:
                begin
                    run = ($urandom_range(9) == 0) ? $urandom_range(6, 20)
                                                   : $urandom_range(1, 4);
                    if (!($urandom_range(7) == 0 && stream_bytes.size() != 0))
                        v = BYTE_W'($urandom);
                    repeat (run)
                        if (stream_bytes.size() < len)
                            stream_bytes.push_back(v);
                end
                SEQ_NOISE:
                    stream_bytes.push_back($urandom_range(1) ? BYTE_W'($urandom_range(2))
                                                             : BYTE_W'($urandom));
                SEQ_RUN:
                    stream_bytes.push_back(v);
                default:
                begin
                    v = v + BYTE_W'($urandom_range(1, 255));
                    stream_bytes.push_back(v);
                end
            endcase
        end
    endtask

    // Stops offering beats until every predicted word has come out.
    task automatic wait_for_words_out();
        raw.valid <= 1'b0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int phase_start;
        int pick;
        rst_n       <= 1'b0;
        raw.valid   <= 1'b0;
        raw.in_byte <= '0;
        raw.in_last <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed streams: lone bytes at both extremes, a bare pair, a pure
        // literal, a literal closed by a run, a run followed by a literal, and a
        // literal cut short by a trailing pair.
        stream_bytes = {8'h00};
        send_stream();
        stream_bytes = {8'hFF};
        send_stream();
        stream_bytes = {8'h5A, 8'h5A};
        send_stream();
        stream_bytes = {8'h01, 8'h02, 8'h03};
        send_stream();
        stream_bytes = {8'h10, 8'h20, 8'h30, 8'h30, 8'h30};
        send_stream();
        stream_bytes = {8'h77, 8'h77, 8'h77, 8'h80, 8'h81};
        send_stream();
        stream_bytes = {8'hAA, 8'hBB, 8'hAA, 8'hAA};
        send_stream();

        // Three phases of random streams: receiver idles more, then sender idles
        // more, then neither. Each phase ends by draining all expected words.
        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_idle_pct = 46;
                recv_idle_pct <= 35;
            end
            else if (phase == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
                // Lone-byte streams while the receiver is held off: each one closes
                // a word, so the encoder backs up all the way to its input.
                hold_go <= 1'b1;
                for (int k = 0; k < 8; k++)
                begin
                    build_stream(SEQ_RUN, 1);
                    send_stream();
                end
            end
            phase_start = items_sent;
            while (items_sent - phase_start < 22)
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                    build_stream(SEQ_MIXED, $urandom_range(1, 24));
                else if (pick < 85)
                    build_stream(SEQ_NOISE, $urandom_range(1, 16));
                else if (pick < 95)
                    build_stream(SEQ_RUN, $urandom_range(2, 12));
                else
                    build_stream(SEQ_LITERAL, $urandom_range(3, 20));
                send_stream();
            end
            wait_for_words_out();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && words_due == 0)
            $display("PASS packbits_encoder_core");
        else
            $display("FAIL packbits_encoder_core");
        $finish;
    end

endmodule
